>>> design/sfr_pkg.sv
// Shared types, constants and register codes for the SBUS frame receiver.
`timescale 1ns / 1ps
package sfr_pkg;

    // Frame layout
    localparam int PAYLOAD_BYTES_DEF = 24;
    localparam int NUM_CHANNELS      = 16;
    localparam int CHAN_BITS         = 11;
    localparam int CH_IDX_W          = $clog2(NUM_CHANNELS);
    localparam int FLAG_BYTE         = 22;
    localparam logic [CHAN_BITS-1:0] CHAN_MASK = 11'h7FF;

    // Bit accumulator in the channel unpacker: up to ten leftover bits plus one byte
    localparam int ACC_W = CHAN_BITS - 1 + 8;
    localparam int NB_W  = $clog2(ACC_W + 1);

    // Idle tick counter
    localparam int IDLE_W = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER     = 3'd0,
        CFG_FOOTER     = 3'd1,
        CFG_ALT_MASK   = 3'd2,
        CFG_ALT_VALUE  = 3'd3,
        CFG_LOST_MASK  = 3'd4,
        CFG_FS_MASK    = 3'd5,
        CFG_TIMEOUT    = 3'd6
    } t_cfg_idx;

    localparam logic [7:0]  RST_HEADER    = 8'd15;
    localparam logic [7:0]  RST_FOOTER    = 8'd0;
    localparam logic [7:0]  RST_ALT_MASK  = 8'd15;
    localparam logic [7:0]  RST_ALT_VALUE = 8'd4;
    localparam logic [7:0]  RST_LOST_MASK = 8'd4;
    localparam logic [7:0]  RST_FS_MASK   = 8'd8;
    localparam logic [15:0] RST_TIMEOUT   = 16'd7000;

    // Completed frame handed from the front end to the unpacker
    typedef struct packed {
        logic bank;
        logic failsafe;
        logic lost_frame;
    } t_frame_tok;

    // Unpacker gives a payload bank back to the front end
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_EMIT
    } t_back_state;

endpackage

>>> design/sfr_if.sv
// Handshake channels of the SBUS frame receiver: received items and channel results.
`timescale 1ns / 1ps
interface sfr_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, kind, rx_byte, input ready);
    modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface sfr_chan_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        failsafe;
    logic        lost_frame;
    logic        last;

    modport source (output valid, channel_index, channel_value, failsafe, lost_frame, last,
                    input ready);
    modport sink   (input valid, channel_index, channel_value, failsafe, lost_frame, last,
                    output ready);
endinterface

>>> design/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/sfr_front.sv
// Front end: configuration registers, idle timeout, frame hunt and payload capture.
`timescale 1ns / 1ps
module sfr_front #(
    parameter int PAYLOAD_BYTES = sfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    sfr_item_if.sink                            i_item,
    input  logic                                i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_ram_we,
    output logic [$clog2(PAYLOAD_BYTES):0]      o_ram_waddr,
    output logic [7:0]                          o_ram_wdata,
    output logic                                o_push,
    output sfr_pkg::t_frame_tok                 o_tok,
    input  logic                                i_queue_full,
    input  sfr_pkg::t_release                   i_release
);
    import sfr_pkg::*;

    localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int SA_W  = $clog2(PAYLOAD_BYTES);

    // Configuration registers
    logic [7:0]  r_header, r_footer, r_alt_mask, r_alt_value, r_lost_mask, r_fs_mask;
    logic [15:0] r_timeout;

    // Receive state
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_prev;
    logic [IDLE_W-1:0] r_idle, n_idle;
    logic              r_wbank;
    logic [1:0]        r_busy, n_busy;
    logic [7:0]        r_flags;

    logic             byte_acc, tick_acc, timed_out, hunting, last_slot;
    logic             prev_footer, byte_footer;
    logic [POS_W-1:0] pos_eff;
    logic [SA_W-1:0]  slot;

    // Apply configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= RST_HEADER;
            r_footer    <= RST_FOOTER;
            r_alt_mask  <= RST_ALT_MASK;
            r_alt_value <= RST_ALT_VALUE;
            r_lost_mask <= RST_LOST_MASK;
            r_fs_mask   <= RST_FS_MASK;
            r_timeout   <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HEADER:    r_header    <= i_cfg_data[7:0];
                CFG_FOOTER:    r_footer    <= i_cfg_data[7:0];
                CFG_ALT_MASK:  r_alt_mask  <= i_cfg_data[7:0];
                CFG_ALT_VALUE: r_alt_value <= i_cfg_data[7:0];
                CFG_LOST_MASK: r_lost_mask <= i_cfg_data[7:0];
                CFG_FS_MASK:   r_fs_mask   <= i_cfg_data[7:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold byte items while the bank to be filled still waits for the unpacker
    assign i_item.ready = i_item.kind | ~r_busy[r_wbank];

    assign byte_acc = i_item.valid & i_item.ready & ~i_item.kind;
    assign tick_acc = i_item.valid & i_item.ready & i_item.kind;

    // Classify the byte: timeout first, then hunt or store
    assign timed_out   = r_idle > IDLE_W'(r_timeout);
    assign pos_eff     = timed_out ? '0 : r_pos;
    assign hunting     = (pos_eff == '0) || (pos_eff > POS_W'(PAYLOAD_BYTES));
    assign last_slot   = pos_eff == POS_W'(PAYLOAD_BYTES);
    assign slot        = SA_W'(pos_eff - POS_W'(1));
    assign prev_footer = (r_prev == r_footer) || ((r_prev & r_alt_mask) == r_alt_value);
    assign byte_footer = (i_item.rx_byte == r_footer) ||
                         ((i_item.rx_byte & r_alt_mask) == r_alt_value);

    always_comb begin
        n_pos = r_pos;
        if (byte_acc) begin
            if (hunting) begin
                n_pos = (i_item.rx_byte == r_header && prev_footer) ? POS_W'(1) : '0;
            end else if (last_slot) begin
                n_pos = '0;
            end else begin
                n_pos = pos_eff + POS_W'(1);
            end
        end
    end

    // Count ticks since the last byte, saturating
    always_comb begin
        n_idle = r_idle;
        if (byte_acc) begin
            n_idle = '0;
        end else if (tick_acc && r_idle != '1) begin
            n_idle = r_idle + IDLE_W'(1);
        end
    end

    // Payload store write and frame completion
    assign o_ram_we    = byte_acc & ~hunting;
    assign o_ram_waddr = {r_wbank, slot};
    assign o_ram_wdata = i_item.rx_byte;
    assign o_push      = o_ram_we & last_slot & byte_footer;

    assign o_tok.bank       = r_wbank;
    assign o_tok.failsafe   = |(r_flags & r_fs_mask);
    assign o_tok.lost_frame = |(r_flags & r_lost_mask);

    // Mark banks handed to the unpacker, clear them when it is done
    always_comb begin
        n_busy = r_busy;
        if (o_push) begin
            n_busy[r_wbank] = 1'b1;
        end
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_prev  <= '0;
            r_idle  <= '0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_idle <= n_idle;
            r_busy <= n_busy;
            // Previous byte follows every byte, frame end included
            if (byte_acc) begin
                r_prev <= i_item.rx_byte;
            end
            if (o_push) begin
                r_wbank <= ~r_wbank;
            end
        end
    end

    // Keep the flag byte for the token
    always_ff @(posedge i_clk) begin
        if (o_ram_we && slot == SA_W'(FLAG_BYTE)) begin
            r_flags <= i_item.rx_byte;
        end
    end

    a_no_write_busy_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> !r_busy[r_wbank])
        else $error("payload write into a bank held by the unpacker");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_queue_full)
        else $error("frame token pushed into a full queue");

endmodule

>>> design/sfr_queue.sv
// Two-entry queue of completed frame tokens between front end and unpacker.
`timescale 1ns / 1ps
module sfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfr_pkg::t_frame_tok i_tok,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output sfr_pkg::t_frame_tok o_tok
);
    import sfr_pkg::*;

    t_frame_tok r_buf [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;

    assign o_valid = r_count != 2'd0;
    assign o_full  = r_count == 2'd2;
    assign o_tok   = r_buf[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_tok;
        end
    end

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("token popped from an empty queue");

endmodule

>>> design/sfr_back.sv
// Unpacker: reads a stored frame byte by byte and emits sixteen 11-bit channels.
`timescale 1ns / 1ps
module sfr_back #(
    parameter int PAYLOAD_BYTES = sfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tok_valid,
    input  sfr_pkg::t_frame_tok            i_tok,
    output logic                           o_pop,
    output logic                           o_ram_re,
    output logic [$clog2(PAYLOAD_BYTES):0] o_ram_raddr,
    input  logic [7:0]                     i_ram_rdata,
    output sfr_pkg::t_release              o_release,
    sfr_chan_if.source                     o_chan
);
    import sfr_pkg::*;

    localparam int SA_W = $clog2(PAYLOAD_BYTES);

    t_back_state          r_state, n_state;
    logic                 r_bank, r_fs, r_lf;
    logic [SA_W-1:0]      r_rd;
    logic [ACC_W-1:0]     r_acc;
    logic [NB_W-1:0]      r_nbits;
    logic [CH_IDX_W-1:0]  r_chan;

    logic                 r_out_valid;
    logic [CH_IDX_W-1:0]  r_out_index;
    logic [CHAN_BITS-1:0] r_out_value;
    logic                 r_out_fs, r_out_lf, r_out_last;

    logic out_free, emit, chan_last;

    assign out_free  = ~r_out_valid | o_chan.ready;
    assign chan_last = r_chan == CH_IDX_W'(NUM_CHANNELS - 1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_tok_valid) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: n_state = BK_LOAD;
            BK_LOAD: begin
                n_state = (r_nbits + NB_W'(8) >= NB_W'(CHAN_BITS)) ? BK_EMIT : BK_READ;
            end
            BK_EMIT: begin
                if (out_free) begin
                    if (chan_last) begin
                        n_state = BK_IDLE;
                    end else if (r_nbits - NB_W'(CHAN_BITS) >= NB_W'(CHAN_BITS)) begin
                        n_state = BK_EMIT;
                    end else begin
                        n_state = BK_READ;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop    = 1'b0;
        o_ram_re = 1'b0;
        emit     = 1'b0;
        case (r_state)
            BK_IDLE: o_pop    = i_tok_valid;
            BK_READ: o_ram_re = 1'b1;
            BK_EMIT: emit     = out_free;
            default: ;
        endcase
    end

    assign o_ram_raddr       = {r_bank, r_rd};
    assign o_release.valid   = emit & chan_last;
    assign o_release.bank    = r_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_chan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Bit accumulator: append bytes LSB-first, drop channels from the bottom
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bank  <= i_tok.bank;
            r_fs    <= i_tok.failsafe;
            r_lf    <= i_tok.lost_frame;
            r_rd    <= '0;
            r_acc   <= '0;
            r_nbits <= '0;
            r_chan  <= '0;
        end
        if (o_ram_re) begin
            r_rd <= r_rd + SA_W'(1);
        end
        if (r_state == BK_LOAD) begin
            r_acc   <= r_acc | (ACC_W'(i_ram_rdata) << r_nbits);
            r_nbits <= r_nbits + NB_W'(8);
        end
        if (emit) begin
            r_acc       <= r_acc >> CHAN_BITS;
            r_nbits     <= r_nbits - NB_W'(CHAN_BITS);
            r_chan      <= r_chan + CH_IDX_W'(1);
            r_out_index <= r_chan;
            r_out_value <= r_acc[CHAN_BITS-1:0] & CHAN_MASK;
            r_out_fs    <= r_fs;
            r_out_lf    <= r_lf;
            r_out_last  <= chan_last;
        end
    end

    assign o_chan.valid         = r_out_valid;
    assign o_chan.channel_index = r_out_index;
    assign o_chan.channel_value = r_out_value;
    assign o_chan.failsafe      = r_out_fs;
    assign o_chan.lost_frame    = r_out_lf;
    assign o_chan.last          = r_out_last;

    a_emit_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EMIT) |-> (r_nbits >= NB_W'(CHAN_BITS)))
        else $error("channel emitted with too few accumulated bits");

    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_re |=> (r_state == BK_LOAD))
        else $error("store read not followed by a load");

endmodule

>>> design/sbus_frame_receiver_core.sv
// Top level of the SBUS frame receiver: front end, token queue, payload RAM, unpacker.
//
//  Port       | Dir | Handshake    | Carries
//  -----------+-----+--------------+-------------------------------------------
//  i_item     | in  | valid/ready  | kind (byte or microsecond tick), rx_byte
//  o_chan     | out | valid/ready  | channel_index, channel_value, flags, last
//  i_cfg_*    | in  | write enable | register index and data, no read-back
//
//  A completed frame is unpacked by popping its token, then reading and loading each
//  of its 22 payload bytes through the single read port of the payload RAM and
//  emitting each of the 16 channels once enough bits are held; an emit waits while
//  the output stalls. Two payload banks let a new frame be captured while the
//  previous one unpacks; bytes stall only when both banks wait. Synchronous reset
//  restores register defaults and the header hunt; the payload RAM is not cleared.
`timescale 1ns / 1ps
module sbus_frame_receiver_core #(
    parameter int PAYLOAD_BYTES = sfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sfr_item_if.sink                       i_item,
    sfr_chan_if.source                     o_chan,
    input  logic                           i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfr_pkg::*;

    localparam int RAM_AW = $clog2(PAYLOAD_BYTES) + 1;

    logic              ram_we, ram_re;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic              push, pop, q_valid, q_full;
    t_frame_tok        push_tok, pop_tok;
    t_release          release_bank;

    sfr_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_push       (push),
        .o_tok        (push_tok),
        .i_queue_full (q_full),
        .i_release    (release_bank)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_tok   (pop_tok)
    );

    // Two payload banks
    sfr_ram #(
        .WIDTH (8),
        .DEPTH (2 ** RAM_AW)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sfr_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (pop_tok),
        .o_pop       (pop),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_release   (release_bank),
        .o_chan      (o_chan)
    );

endmodule
